// ===== rtl/mpva_pkg.sv =====
package mpva_pkg;

    // Message type nibbles of the status byte
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_CONTROL  = 4'hB;
    localparam logic [3:0] NIB_WHEEL    = 4'hE;

    // Bit positions in the type mask register
    localparam int TYPE_BIT_ON    = 0;
    localparam int TYPE_BIT_OFF   = 1;
    localparam int TYPE_BIT_CC    = 2;
    localparam int TYPE_BIT_WHEEL = 3;

    // Configuration register indexes
    localparam logic [1:0] REG_CHANNEL_MASK  = 2'd0;
    localparam logic [1:0] REG_TYPE_MASK     = 2'd1;
    localparam logic [1:0] REG_KEY_MASK_LOW  = 2'd2;
    localparam logic [1:0] REG_KEY_MASK_HIGH = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // Event kinds reported on the result stream
    typedef enum logic [2:0] {
        EV_FILTERED  = 3'd0,
        EV_VOICE_ON  = 3'd1,
        EV_VOICE_OFF = 3'd2,
        EV_OFF_MISS  = 3'd3,
        EV_CONTROL   = 3'd4,
        EV_WHEEL     = 3'd5
    } event_kind_t;

    // Scaling constants for the millivolt conversions
    localparam logic [13:0] VEL_SCALE    = 14'd10000;
    localparam logic [14:0] CV_SCALE     = 15'd20000;
    localparam logic [15:0] CV_OFFSET    = 16'd10000;
    localparam logic [7:0]  PITCH_OFFSET = 8'd53;
    localparam logic [12:0] BIAS_SEVEN   = 13'd63;
    localparam logic [12:0] BIAS_WHEEL   = 13'd8191;
    localparam logic [15:0] DIV_SEVEN    = 16'd127;
    localparam logic [15:0] DIV_WHEEL    = 16'd16383;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic do_mul;
        logic do_est;
        logic do_fix;
        logic scan_clr;
        logic scan_step;
        logic commit;
    } mpva_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } mpva_sts_t;

endpackage

// ===== rtl/midi_poly_voice_allocator_core.sv =====
// Each message runs through scaling, quotient estimate, correction, a voice scan of one voice
// per cycle and a commit that loads the result register.
// A new message is taken only after the previous one commits; the voice scan sets the
// pace, and a pending result stalls only the commit step.
// Reset (aresetn low, synchronous): masks, gates, keys, stamps and age counter clear.
module midi_poly_voice_allocator_core #(
    parameter int VOICES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // status_byte[7:0], data_one[14:8], data_two[21:15], zero pad[23:22]
    input  logic [mpva_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // voice_index[2:0], voice_stolen[3], pitch_semitones[11:4], velocity_mv[25:12],
    // control_mv[40:26], wheel_mv[55:41]
    output logic [mpva_pkg::M_TDATA_W-1:0]       m_tdata,
    // event_kind[2:0]
    output logic [mpva_pkg::M_TUSER_W-1:0]       m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpva_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpva_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mpva_pkg::mpva_cmd_t   cmd;
    mpva_pkg::mpva_sts_t   sts;
    mpva_pkg::event_kind_t out_kind;
    logic [2:0]            out_voice;
    logic                  out_stolen;
    logic signed [7:0]     out_pitch;
    logic [13:0]           out_velocity;
    logic signed [14:0]    out_control;
    logic signed [14:0]    out_wheel;

    assign cfg_ready = 1'b1;

    mpva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mpva_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_status    (s_tdata[7:0]),
        .in_data_one  (s_tdata[14:8]),
        .in_data_two  (s_tdata[21:15]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_kind     (out_kind),
        .out_voice    (out_voice),
        .out_stolen   (out_stolen),
        .out_pitch    (out_pitch),
        .out_velocity (out_velocity),
        .out_control  (out_control),
        .out_wheel    (out_wheel)
    );

    // Pack the result fields, first field lowest
    assign m_tdata = {out_wheel, out_control, out_velocity, out_pitch, out_stolen, out_voice};
    assign m_tuser = out_kind;

endmodule

// ===== rtl/mpva_ctrl.sv =====
module mpva_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mpva_pkg::mpva_sts_t sts,
    output mpva_pkg::mpva_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EST,
        ST_FIX1,
        ST_FIX2,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    // Sequence one message: scale, estimate, correct, voice scan, commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_MUL;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_MUL:  state_reg <= ST_EST;
                ST_EST:  state_reg <= ST_FIX1;
                ST_FIX1: state_reg <= ST_FIX2;
                ST_FIX2: state_reg <= ST_SCAN;
                ST_SCAN: begin
                    if (sts.scan_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (sts.out_free) begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = s_tready_reg;

    // Decode commands from state
    always_comb begin
        cmd           = '0;
        cmd.load_in   = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
        cmd.do_mul    = (state_reg == ST_MUL);
        cmd.scan_clr  = (state_reg == ST_MUL);
        cmd.do_est    = (state_reg == ST_EST);
        cmd.do_fix    = (state_reg == ST_FIX1) || (state_reg == ST_FIX2);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.commit    = (state_reg == ST_DONE) && sts.out_free;
    end

endmodule

// ===== rtl/mpva_dp.sv =====
module mpva_dp #(
    parameter int VOICES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mpva_pkg::mpva_cmd_t                  cmd,
    output mpva_pkg::mpva_sts_t                  sts,
    input  logic [7:0]                           in_status,
    input  logic [6:0]                           in_data_one,
    input  logic [6:0]                           in_data_two,
    input  logic                                 cfg_valid,
    input  logic [mpva_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpva_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output mpva_pkg::event_kind_t                out_kind,
    output logic [2:0]                           out_voice,
    output logic                                 out_stolen,
    output logic signed [7:0]                    out_pitch,
    output logic [13:0]                          out_velocity,
    output logic signed [14:0]                   out_control,
    output logic signed [14:0]                   out_wheel
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    // Configuration registers
    logic [15:0] channel_mask_reg;
    logic [3:0]  type_mask_reg;
    logic [63:0] key_mask_low_reg;
    logic [63:0] key_mask_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_mask_reg  <= '0;
            type_mask_reg     <= '0;
            key_mask_low_reg  <= '0;
            key_mask_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mpva_pkg::REG_CHANNEL_MASK:  channel_mask_reg  <= cfg_data[15:0];
                mpva_pkg::REG_TYPE_MASK:     type_mask_reg     <= cfg_data[3:0];
                mpva_pkg::REG_KEY_MASK_LOW:  key_mask_low_reg  <= cfg_data;
                mpva_pkg::REG_KEY_MASK_HIGH: key_mask_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the message
    logic [7:0] status_reg;
    logic [6:0] d1_reg;
    logic [6:0] d2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            status_reg <= in_status;
            d1_reg     <= in_data_one;
            d2_reg     <= in_data_two;
        end
    end

    // Decode type and apply the masks
    logic [3:0] nib;
    logic       is_on, is_off, is_cc, is_wheel;
    logic       type_ok, chan_ok, key_ok, pass;

    always_comb begin
        nib      = status_reg[7:4];
        is_on    = (nib == mpva_pkg::NIB_NOTE_ON);
        is_off   = (nib == mpva_pkg::NIB_NOTE_OFF);
        is_cc    = (nib == mpva_pkg::NIB_CONTROL);
        is_wheel = (nib == mpva_pkg::NIB_WHEEL);
        type_ok  = (is_on    && type_mask_reg[mpva_pkg::TYPE_BIT_ON])
                || (is_off   && type_mask_reg[mpva_pkg::TYPE_BIT_OFF])
                || (is_cc    && type_mask_reg[mpva_pkg::TYPE_BIT_CC])
                || (is_wheel && type_mask_reg[mpva_pkg::TYPE_BIT_WHEEL]);
        chan_ok  = channel_mask_reg[status_reg[3:0]];
        key_ok   = d1_reg[6] ? key_mask_high_reg[d1_reg[5:0]]
                             : key_mask_low_reg[d1_reg[5:0]];
        pass     = type_ok && chan_ok && key_ok;
    end

    // Scale the data byte, then divide by 127 or 16383 with rounding bias
    logic [28:0] num_reg;
    logic [14:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] divisor;
    logic [13:0] bend;
    logic [28:0] num_next;
    logic [30:0] est_sum;
    logic [14:0] est_q;
    logic [29:0] est_prod;
    logic [29:0] est_rem;

    always_comb begin
        bend    = {d2_reg, d1_reg};
        divisor = is_wheel ? mpva_pkg::DIV_WHEEL : mpva_pkg::DIV_SEVEN;
        if (is_wheel) begin
            num_next = 29'(bend) * 29'(mpva_pkg::CV_SCALE) + 29'(mpva_pkg::BIAS_WHEEL);
        end else if (is_cc) begin
            num_next = 29'(d2_reg) * 29'(mpva_pkg::CV_SCALE) + 29'(mpva_pkg::BIAS_SEVEN);
        end else begin
            num_next = 29'(d2_reg) * 29'(mpva_pkg::VEL_SCALE) + 29'(mpva_pkg::BIAS_SEVEN);
        end
        // 1/(2^n - 1) as a short series of shifts; falls short by at most one
        if (is_wheel) begin
            est_sum = 31'(num_reg) + 31'(num_reg >> 14) + 31'(num_reg >> 28);
            est_q   = 15'(est_sum >> 14);
            est_prod = {1'b0, est_q, 14'b0} - 30'(est_q);
        end else begin
            est_sum = 31'(num_reg) + 31'(num_reg >> 7) + 31'(num_reg >> 14)
                    + 31'(num_reg >> 21);
            est_q   = 15'(est_sum >> 7);
            est_prod = 30'({est_q, 7'b0}) - 30'(est_q);
        end
        est_rem = 30'(num_reg) - est_prod;
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_mul) begin
            num_reg <= num_next;
        end
        if (cmd.do_est) begin
            quo_reg <= est_q;
            rem_reg <= est_rem[15:0];
        end else if (cmd.do_fix && (rem_reg >= divisor)) begin
            quo_reg <= quo_reg + 15'd1;
            rem_reg <= rem_reg - divisor;
        end
    end

    // Voice state
    logic [VOICES-1:0] gate_reg;
    logic [6:0]        key_reg   [VOICES];
    logic [31:0]       stamp_reg [VOICES];
    logic [31:0]       age_reg;

    // Scan one voice a cycle: first free, oldest stamp, first open match
    logic [IDX_W-1:0] scan_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic [31:0]      min_stamp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            scan_idx_reg    <= '0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (!free_found_reg && !gate_reg[scan_idx_reg]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
            if (!match_found_reg && gate_reg[scan_idx_reg]
                    && (key_reg[scan_idx_reg] == d1_reg)) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= scan_idx_reg;
            end
            if ((scan_idx_reg == '0) || (stamp_reg[scan_idx_reg] < min_stamp_reg)) begin
                min_idx_reg   <= scan_idx_reg;
                min_stamp_reg <= stamp_reg[scan_idx_reg];
            end
        end
    end

    assign sts.scan_last = (scan_idx_reg == LAST_IDX);

    // Commit: update voices and load the result register
    logic [IDX_W-1:0] on_idx;
    logic [31:0]      age_next;
    logic [15:0]      cv_diff;
    logic             m_tvalid_reg;

    assign on_idx       = free_found_reg ? free_idx_reg : min_idx_reg;
    assign age_next     = age_reg + 32'd1;
    assign cv_diff      = {1'b0, quo_reg} - mpva_pkg::CV_OFFSET;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg     <= '0;
            age_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                key_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
            out_kind     <= mpva_pkg::EV_FILTERED;
            out_voice    <= '0;
            out_stolen   <= 1'b0;
            out_pitch    <= '0;
            out_velocity <= '0;
            out_control  <= '0;
            out_wheel    <= '0;
            if (pass) begin
                priority if (is_on) begin
                    age_reg            <= age_next;
                    gate_reg[on_idx]   <= 1'b1;
                    key_reg[on_idx]    <= d1_reg;
                    stamp_reg[on_idx]  <= age_next;
                    out_kind           <= mpva_pkg::EV_VOICE_ON;
                    out_voice          <= 3'(on_idx);
                    out_stolen         <= !free_found_reg;
                    out_pitch          <= {1'b0, d1_reg} - mpva_pkg::PITCH_OFFSET;
                    out_velocity       <= quo_reg[13:0];
                end else if (is_off) begin
                    if (match_found_reg) begin
                        gate_reg[match_idx_reg] <= 1'b0;
                        out_kind                <= mpva_pkg::EV_VOICE_OFF;
                        out_voice               <= 3'(match_idx_reg);
                    end else begin
                        out_kind <= mpva_pkg::EV_OFF_MISS;
                    end
                end else if (is_cc) begin
                    out_kind    <= mpva_pkg::EV_CONTROL;
                    out_control <= cv_diff[14:0];
                end else begin
                    out_kind  <= mpva_pkg::EV_WHEEL;
                    out_wheel <= cv_diff[14:0];
                end
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/mpva_checker.sv =====
module mpva_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [mpva_pkg::M_TDATA_W-1:0]       m_tdata,
    input logic [mpva_pkg::M_TUSER_W-1:0]       m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    // One message in flight: input closes after each transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A filtered message carries all-zero fields
    a_filtered_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpva_pkg::EV_FILTERED) |-> (m_tdata == '0))
        else $error("filtered result with nonzero fields");

    // An unmatched note off touches no voice
    a_miss_no_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpva_pkg::EV_OFF_MISS) |-> (m_tdata == '0))
        else $error("unmatched note off with nonzero fields");

    // Only voice-on results may flag a steal
    a_steal_on_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> (m_tuser == mpva_pkg::EV_VOICE_ON))
        else $error("steal flag on a result other than voice on");

endmodule

bind midi_poly_voice_allocator_core mpva_checker u_mpva_checker (.*);
